@@ hdl/qdcd_pkg.sv @@
// Shared types, codes and helpers for the int8 detection-cell decoder.
// No dependencies; imported by every qdcd module and the top level.
`timescale 1ns / 1ps
`default_nettype none

package qdcd_pkg;

	localparam int Q_W    = 8;
	localparam int BIDX_W = 10;
	localparam int A_W    = 26;
	localparam int B_W    = 17;
	localparam int PROD_W = 43;
	localparam int BOX_W  = 20;
	localparam int PROB_W = 25;
	localparam int IN_W   = 24;
	localparam int OUT_W  = 120;
	localparam int CFG_W  = 16;

	typedef enum logic [1:0] {
		ACT_SUM   = 2'd0,
		ACT_CLASS = 2'd1,
		ACT_BOX   = 2'd2,
		ACT_NOP   = 2'd3
	} act_t;

	typedef enum logic [2:0] {
		REG_CLASS_THR  = 3'd0,
		REG_SUM_THR    = 3'd1,
		REG_SUM_GATE   = 3'd2,
		REG_SCORE_ZP   = 3'd3,
		REG_SCORE_SCL  = 3'd4,
		REG_BOX_ZP     = 3'd5,
		REG_BOX_SCL    = 3'd6,
		REG_STRIDE     = 3'd7
	} cfg_idx_t;

	typedef enum logic [3:0] {
		OP_D0 = 4'd0,
		OP_D1 = 4'd1,
		OP_D2 = 4'd2,
		OP_D3 = 4'd3,
		OP_X  = 4'd4,
		OP_Y  = 4'd5,
		OP_W  = 4'd6,
		OP_H  = 4'd7,
		OP_P  = 4'd8
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_RUN  = 2'd1,
		ST_WB   = 2'd2,
		ST_DONE = 2'd3
	} seq_state_t;

	typedef struct packed {
		logic signed [7:0] class_thr;
		logic signed [7:0] sum_thr;
		logic              sum_gate;
		logic signed [7:0] score_zero;
		logic [15:0]       score_gain;
		logic signed [7:0] box_zp;
		logic [15:0]       box_gain;
		logic [7:0]        stride;
	} cfg_t;

	typedef struct packed {
		logic              go;
		logic signed [7:0] best;
		logic [BIDX_W-1:0] best_class;
		logic signed [7:0] d0;
		logic signed [7:0] d1;
		logic signed [7:0] d2;
	} trk_t;

	function automatic logic signed [8:0] sub8(input logic signed [7:0] x,
		input logic signed [7:0] y);
		return 9'(x) - 9'(y);
	endfunction

	// Q.12 -> Q.4, round half up (floor of v+128 over 256), saturate to 20 bits.
	function automatic logic signed [BOX_W-1:0] q12_to_q4(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W:0] t;
		logic signed [PROD_W-8:0] r;
		t = (PROD_W+1)'(v) + (PROD_W+1)'(signed'(128));
		r = t[PROD_W:8];
		if (r < -(PROD_W-7)'(signed'(524288)))
			return -BOX_W'(signed'(524288));
		else if (r > (PROD_W-7)'(signed'(524287)))
			return BOX_W'(signed'(524287));
		else
			return r[BOX_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ hdl/quantized_detection_cell_decode.sv @@
// Top level: config registers, sequencer around the shared multiplier, output register.
// Depends on qdcd_pkg, qdcd_cell_track and qdcd_mul_unit.
// A result is loaded into the output register after the RUN, WB and DONE states that follow the fourth box distance.
// Throughput: one input transaction per cycle, except that an emitting cell holds
// s_tready low through the RUN, WB and DONE states while nine multiplies share one
// multiplier, and stays in DONE while the previous result still waits for m_tready.
// Reset: arst_n clears config to defaults, cell state, sequencer and m_tvalid.
`timescale 1ns / 1ps
`default_nettype none

module quantized_detection_cell_decode
	import qdcd_pkg::*;
#(
	parameter int NUM_CLASSES = 80
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [IN_W-1:0]   s_tdata,  // quant_value, cell_row, cell_col
	input  wire logic [1:0]        s_tuser,  // action
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [OUT_W-1:0]       m_tdata,  // left_q4, top_q4, width_q4, height_q4,
	                                         // probability_q16, class_index, zero pad
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.class_thr   <= 8'sd127;
			cfg_q.sum_thr     <= -8'sd128;
			cfg_q.sum_gate    <= 1'b0;
			cfg_q.score_zero  <= 8'sd0;
			cfg_q.score_gain  <= 16'd256;
			cfg_q.box_zp      <= 8'sd0;
			cfg_q.box_gain    <= 16'd4096;
			cfg_q.stride      <= 8'd8;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_CLASS_THR: cfg_q.class_thr   <= signed'(cfg_data[7:0]);
				REG_SUM_THR:   cfg_q.sum_thr     <= signed'(cfg_data[7:0]);
				REG_SUM_GATE:  cfg_q.sum_gate    <= cfg_data[0];
				REG_SCORE_ZP:  cfg_q.score_zero  <= signed'(cfg_data[7:0]);
				REG_SCORE_SCL: cfg_q.score_gain  <= cfg_data;
				REG_BOX_ZP:    cfg_q.box_zp      <= signed'(cfg_data[7:0]);
				REG_BOX_SCL:   cfg_q.box_gain    <= cfg_data;
				REG_STRIDE:    cfg_q.stride      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	logic acc;
	trk_t trk;

	assign acc = s_tvalid && s_tready;

	qdcd_cell_track #(
		.NUM_CLASSES(NUM_CLASSES)
	) u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.action     (s_tuser),
		.quant_value(s_tdata[7:0]),
		.cfg        (cfg_q),
		.trk        (trk)
	);

	// cell snapshot taken on the closing distance
	logic signed [7:0]  q3_q;
	logic [7:0]         row_q;
	logic [7:0]         col_q;
	logic signed [7:0]  best_q;
	logic [BIDX_W-1:0]  cls_q;

	always_ff @(posedge clk) begin
		if (trk.go) begin
			q3_q   <= signed'(s_tdata[7:0]);
			row_q  <= s_tdata[15:8];
			col_q  <= s_tdata[23:16];
			best_q <= trk.best;
			cls_q  <= trk.best_class;
		end
	end

	seq_state_t state_q, state_d;
	op_t        step_q;
	logic       issue;
	logic       out_free;
	logic       load_out;

	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= OP_D0;
		end else begin
			state_q <= state_d;
			if (trk.go)
				step_q <= OP_D0;
			else if (issue)
				step_q <= op_t'(step_q + 4'd1);
		end
	end

	always_comb begin
		state_d  = state_q;
		issue    = 1'b0;
		load_out = 1'b0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (trk.go)
					state_d = ST_RUN;
			end
			ST_RUN: begin
				issue = 1'b1;
				if (step_q == OP_P)
					state_d = ST_WB;
			end
			ST_WB: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// operand select for the shared multiplier
	logic signed [A_W-1:0]    d_q [4];
	logic signed [A_W-1:0]    mul_a;
	logic signed [B_W-1:0]    mul_b;
	logic signed [B_W-1:0]    box_scl;
	logic signed [B_W-1:0]    stride_b;
	logic signed [A_W-1:0]    col_base;
	logic signed [A_W-1:0]    row_base;

	assign box_scl  = signed'({1'b0, cfg_q.box_gain});
	assign stride_b = signed'({9'b0, cfg_q.stride});
	assign col_base = signed'({6'b0, col_q, 12'h800});
	assign row_base = signed'({6'b0, row_q, 12'h800});

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (step_q)
			OP_D0: begin mul_a = A_W'(sub8(trk.d0, cfg_q.box_zp)); mul_b = box_scl; end
			OP_D1: begin mul_a = A_W'(sub8(trk.d1, cfg_q.box_zp)); mul_b = box_scl; end
			OP_D2: begin mul_a = A_W'(sub8(trk.d2, cfg_q.box_zp)); mul_b = box_scl; end
			OP_D3: begin mul_a = A_W'(sub8(q3_q, cfg_q.box_zp));   mul_b = box_scl; end
			OP_X:  begin mul_a = col_base - d_q[0]; mul_b = stride_b; end
			OP_Y:  begin mul_a = row_base - d_q[1]; mul_b = stride_b; end
			OP_W:  begin mul_a = d_q[0] + d_q[2];   mul_b = stride_b; end
			OP_H:  begin mul_a = d_q[1] + d_q[3];   mul_b = stride_b; end
			OP_P: begin
				mul_a = A_W'(sub8(best_q, cfg_q.score_zero));
				mul_b = signed'({1'b0, cfg_q.score_gain});
			end
			default: ;
		endcase
	end

	logic                      mul_vld;
	op_t                       mul_tag;
	logic signed [PROD_W-1:0]  mul_prod;

	qdcd_mul_unit u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.issue (issue),
		.op    (step_q),
		.a     (mul_a),
		.b     (mul_b),
		.vld   (mul_vld),
		.tag   (mul_tag),
		.prod  (mul_prod)
	);

	logic signed [BOX_W-1:0]   left_q, top_q, width_q, height_q;
	logic signed [PROB_W-1:0]  prob_q;

	always_ff @(posedge clk) begin
		if (mul_vld) begin
			unique case (mul_tag)
				OP_D0: d_q[0]   <= mul_prod[A_W-1:0];
				OP_D1: d_q[1]   <= mul_prod[A_W-1:0];
				OP_D2: d_q[2]   <= mul_prod[A_W-1:0];
				OP_D3: d_q[3]   <= mul_prod[A_W-1:0];
				OP_X:  left_q   <= q12_to_q4(mul_prod);
				OP_Y:  top_q    <= q12_to_q4(mul_prod);
				OP_W:  width_q  <= q12_to_q4(mul_prod);
				OP_H:  height_q <= q12_to_q4(mul_prod);
				OP_P:  prob_q   <= mul_prod[PROB_W-1:0];
				default: ;
			endcase
		end
	end

	logic [OUT_W-1:0] out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (load_out)
			m_tvalid <= 1'b1;
		else if (m_tready)
			m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out)
			out_q <= {5'b0, cls_q, prob_q, height_q, width_q, top_q, left_q};
	end

	assign m_tdata = out_q;

	a_done_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> !mul_vld)
		else $error("result loaded with a product still pending");

	a_ready_idle_unit: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !mul_vld)
		else $error("input taken while multiplier busy");

	a_go_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		trk.go |=> state_q == ST_RUN && step_q == OP_D0)
		else $error("emitting cell did not start the sequence");

	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside the done state");

endmodule

`default_nettype wire

@@ hdl/qdcd_cell_track.sv @@
// Per-cell stream tracking: sum gate, running class maximum, box distance capture.
// Depends on qdcd_pkg; raises go on the closing distance of an emitting cell.
`timescale 1ns / 1ps
`default_nettype none

module qdcd_cell_track
	import qdcd_pkg::*;
#(
	parameter int NUM_CLASSES = 80
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         acc,
	input  wire logic [1:0]   action,
	input  wire logic [7:0]   quant_value,
	input  wire cfg_t         cfg,
	output trk_t              trk
);

	localparam int CNT_W = $clog2(NUM_CLASSES + 1);

	logic [CNT_W-1:0]  class_cnt_q;
	logic [1:0]        box_cnt_q;
	logic signed [7:0] best_q;
	logic [BIDX_W-1:0] best_class_q;
	logic              dropped_q;
	logic              found_q;
	logic signed [7:0] dist_q [3];

	logic signed [7:0] q;
	logic signed [7:0] cur_best;
	logic              win;

	assign q        = signed'(quant_value);
	assign cur_best = (class_cnt_q == '0) ? -cfg.score_zero : best_q;
	assign win      = (q > cfg.class_thr) && (q > cur_best);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_cnt_q  <= '0;
			box_cnt_q    <= '0;
			best_q       <= '0;
			best_class_q <= '0;
			dropped_q    <= 1'b0;
			found_q      <= 1'b0;
		end else if (acc) begin
			unique case (act_t'(action))
				ACT_SUM: begin
					if (cfg.sum_gate) begin
						class_cnt_q  <= '0;
						box_cnt_q    <= '0;
						best_q       <= -cfg.score_zero;
						best_class_q <= '0;
						found_q      <= 1'b0;
						dropped_q    <= (q < cfg.sum_thr);
					end
				end
				ACT_CLASS: begin
					if (class_cnt_q < CNT_W'(NUM_CLASSES)) begin
						class_cnt_q <= class_cnt_q + CNT_W'(1);
						best_q      <= win ? q : cur_best;
						if (win) begin
							best_class_q <= BIDX_W'(class_cnt_q);
							found_q      <= 1'b1;
						end
					end
				end
				ACT_BOX: begin
					if (box_cnt_q != 2'd3) begin
						box_cnt_q <= box_cnt_q + 2'd1;
					end else begin
						class_cnt_q  <= '0;
						box_cnt_q    <= '0;
						best_q       <= -cfg.score_zero;
						best_class_q <= '0;
						found_q      <= 1'b0;
						dropped_q    <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// distances: no reset, written before use in every cell
	always_ff @(posedge clk) begin
		if (acc && act_t'(action) == ACT_BOX && box_cnt_q != 2'd3)
			dist_q[box_cnt_q] <= q;
	end

	always_comb begin
		trk.go         = acc && act_t'(action) == ACT_BOX && box_cnt_q == 2'd3 &&
			found_q && !dropped_q;
		trk.best       = best_q;
		trk.best_class = best_class_q;
		trk.d0         = dist_q[0];
		trk.d1         = dist_q[1];
		trk.d2         = dist_q[2];
	end

endmodule

`default_nettype wire

@@ hdl/qdcd_mul_unit.sv @@
// Shared signed multiplier with registered product and operation tag.
// Depends on qdcd_pkg; one issue per cycle, product registered in the next cycle.
`timescale 1ns / 1ps
`default_nettype none

module qdcd_mul_unit
	import qdcd_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    issue,
	input  wire op_t                     op,
	input  wire logic signed [A_W-1:0]   a,
	input  wire logic signed [B_W-1:0]   b,
	output logic                         vld,
	output op_t                          tag,
	output logic signed [PROD_W-1:0]     prod
);

	logic                      vld_q;
	op_t                       tag_q;
	logic signed [PROD_W-1:0]  prod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= 1'b0;
		else
			vld_q <= issue;
	end

	// A_W + B_W == PROD_W: full signed product
	always_ff @(posedge clk) begin
		if (issue) begin
			tag_q  <= op;
			prod_q <= a * b;
		end
	end

	assign vld  = vld_q;
	assign tag  = tag_q;
	assign prod = prod_q;

endmodule

`default_nettype wire
